// ----- rtl/mbd_pkg.sv -----
package mbd_pkg;

   // Field widths
   localparam int CHAN_W = 8;      // one color channel of a source pixel
   localparam int PSUM_W = 9;      // sum of two channels
   localparam int BSUM_W = 10;     // sum of four channels
   localparam int SIZE_W = 12;     // size registers
   localparam int ROW_W  = 11;     // row counter, height never exceeds ROW_LIMIT
   localparam int CSR_IDX_W = 1;

   localparam logic [SIZE_W-1:0] ROW_LIMIT    = 12'd2048;
   localparam logic [SIZE_W-1:0] SIZE_MIN     = 12'd2;
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd256;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd256;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 1'b1;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [PSUM_W-1:0] psum_type;
   typedef logic [BSUM_W-1:0] bsum_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      chan_type alpha;
   } pixel_type;

   typedef struct packed {
      psum_type red;
      psum_type green;
      psum_type blue;
      psum_type alpha;
   } pair_type;

   // Flags carried along with a result in flight
   typedef struct packed {
      logic row_end;
      logic image_end;
   } flags_type;

   // Horizontal pair sum of two pixels
   function automatic pair_type pair_add(input pixel_type a, input pixel_type b);
      pair_type p;
      p.red   = PSUM_W'(a.red)   + PSUM_W'(b.red);
      p.green = PSUM_W'(a.green) + PSUM_W'(b.green);
      p.blue  = PSUM_W'(a.blue)  + PSUM_W'(b.blue);
      p.alpha = PSUM_W'(a.alpha) + PSUM_W'(b.alpha);
      return p;
   endfunction

   // Average of one channel over a 2x2 block, truncated
   function automatic chan_type block_avg(input psum_type a, input psum_type b);
      bsum_type s;
      s = BSUM_W'(a) + BSUM_W'(b);
      return s[BSUM_W-1:2];
   endfunction

endpackage

// ----- rtl/mbd_if.sv -----
// Source pixel channel
interface mbd_req_if;
   logic                 valid;
   logic                 ready;
   mbd_pkg::chan_type    red_in;
   mbd_pkg::chan_type    green_in;
   mbd_pkg::chan_type    blue_in;
   mbd_pkg::chan_type    alpha_in;

   modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// Result pixel channel
interface mbd_rsp_if;
   logic                 valid;
   logic                 ready;
   mbd_pkg::chan_type    red_out;
   mbd_pkg::chan_type    green_out;
   mbd_pkg::chan_type    blue_out;
   mbd_pkg::chan_type    alpha_out;
   logic                 row_end;
   logic                 image_end;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, row_end,
                   image_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, row_end,
                   image_end, output ready);
endinterface

// ----- rtl/mipmap_box_downsample_2x2_top.sv -----
// Channel  Dir  Beat contents
// -------  ---  ------------------------------------------------------------
// req      in   one RGBA8 source pixel, raster order
// rsp      out  one RGBA8 2x2 average, with row_end and image_end flags
// csr      in   write of source_width (index 0) or source_height (index 1)
//
// One source pixel per cycle, sustained, while rsp is taken.
// A result passes the line store read and result stage, then the output register.
// Synchronous reset sets sizes to their reset values and clears counters and
// valid bits; the line store and the result data are not cleared.
// rsp stall: req.ready drops only once the result stage and output register
// are both full.
module mipmap_box_downsample_2x2_top #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   mbd_req_if.sink                           req,
   mbd_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  logic [mbd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mbd_pkg::SIZE_W-1:0]        csr_wdata
);

   // Widths follow the usable row width (register is 12 bits wide)
   localparam int WMAX       = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
   localparam int CW         = $clog2(WMAX);
   localparam int LINE_DEPTH = WMAX / 2;
   localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam logic [mbd_pkg::SIZE_W-1:0] WCAP = mbd_pkg::SIZE_W'(WMAX);

   // Configuration registers
   logic [mbd_pkg::SIZE_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mbd_pkg::WIDTH_RESET;
         height_ff <= mbd_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mbd_pkg::CSR_SOURCE_WIDTH:  width_ff  <= csr_wdata;
            mbd_pkg::CSR_SOURCE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamped sizes
   logic [mbd_pkg::SIZE_W-1:0] w, h, w_last, h_last, w_even_last, h_even_last;

   always_comb begin
      if (width_ff < mbd_pkg::SIZE_MIN)      w = mbd_pkg::SIZE_MIN;
      else if (width_ff > WCAP)              w = WCAP;
      else                                   w = width_ff;
      if (height_ff < mbd_pkg::SIZE_MIN)     h = mbd_pkg::SIZE_MIN;
      else if (height_ff > mbd_pkg::ROW_LIMIT) h = mbd_pkg::ROW_LIMIT;
      else                                   h = height_ff;
      w_last      = w - 1'b1;
      h_last      = h - 1'b1;
      w_even_last = {w[mbd_pkg::SIZE_W-1:1], 1'b0} - 1'b1;
      h_even_last = {h[mbd_pkg::SIZE_W-1:1], 1'b0} - 1'b1;
   end

   // Handshake and stage control
   logic                      accept;
   logic                      s1_valid_ff, s1_valid_in;
   logic                      rsp_valid_ff;
   logic                      out_load;
   logic                      stage_free;

   assign out_load   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign stage_free = !s1_valid_ff || out_load;
   assign req.ready  = stage_free;
   assign accept     = req.valid && stage_free;

   // Position counters
   logic [CW-1:0]            col_ff, col_in;
   logic [mbd_pkg::ROW_W-1:0] row_ff, row_in;
   logic [mbd_pkg::SIZE_W-1:0] col_x, row_x;

   assign col_x = mbd_pkg::SIZE_W'(col_ff);
   assign row_x = mbd_pkg::SIZE_W'(row_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_x >= w_last) begin
            col_in = '0;
            row_in = (row_x >= h_last) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Even-column pixel held for the pair sum
   mbd_pkg::pixel_type pix, now_ff;

   assign pix = '{red: req.red_in, green: req.green_in, blue: req.blue_in,
                  alpha: req.alpha_in};

   always_ff @(posedge clock) begin
      if (reset)                     now_ff <= '0;
      else if (accept && !col_ff[0]) now_ff <= pix;
   end

   // Decode of the current beat
   logic                in_block, wr_en, rd_en;
   logic [AW-1:0]       idx;
   mbd_pkg::pair_type   pair;
   mbd_pkg::flags_type  flags;

   assign in_block = col_ff[0] && (col_x <= w_even_last) && (row_x <= h_even_last);
   assign wr_en    = accept && in_block && !row_ff[0];
   assign rd_en    = accept && in_block && row_ff[0];
   assign idx      = col_ff[AW:1];
   assign pair     = mbd_pkg::pair_add(now_ff, pix);
   assign flags.row_end   = (col_x == w_even_last);
   assign flags.image_end = (col_x == w_even_last) && (row_x == h_even_last);

   // Line store of even-row pair sums
   mbd_pkg::pair_type line_mem [LINE_DEPTH];
   mbd_pkg::pair_type above_ff;

   always_ff @(posedge clock) begin
      if (wr_en) line_mem[idx] <= pair;
      if (rd_en) above_ff <= line_mem[idx];
   end

   // Result stage: lower pair and flags wait for the line store read
   mbd_pkg::pair_type  s1_pair_ff;
   mbd_pkg::flags_type s1_flags_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (stage_free) s1_valid_in = rd_en;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_pair_ff  <= pair;
         s1_flags_ff <= flags;
      end
   end

   // Output register
   mbd_pkg::pixel_type  rsp_pix_ff;
   mbd_pkg::flags_type  rsp_flags_ff;

   always_ff @(posedge clock) begin
      if (reset)         rsp_valid_ff <= 1'b0;
      else if (out_load) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pix_ff.red   <= mbd_pkg::block_avg(above_ff.red,   s1_pair_ff.red);
         rsp_pix_ff.green <= mbd_pkg::block_avg(above_ff.green, s1_pair_ff.green);
         rsp_pix_ff.blue  <= mbd_pkg::block_avg(above_ff.blue,  s1_pair_ff.blue);
         rsp_pix_ff.alpha <= mbd_pkg::block_avg(above_ff.alpha, s1_pair_ff.alpha);
         rsp_flags_ff     <= s1_flags_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.red_out   = rsp_pix_ff.red;
   assign rsp.green_out = rsp_pix_ff.green;
   assign rsp.blue_out  = rsp_pix_ff.blue;
   assign rsp.alpha_out = rsp_pix_ff.alpha;
   assign rsp.row_end   = rsp_flags_ff.row_end;
   assign rsp.image_end = rsp_flags_ff.image_end;

   // Checks
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("beat accepted while result stage is blocked");

   a_read_fills_stage: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> s1_valid_ff)
      else $error("odd-row pair did not reach the result stage");

   a_image_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (!rsp.image_end || rsp.row_end))
      else $error("image end without row end");

   a_no_read_write_same: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("line store read and write in one beat");

endmodule

// ----- tb/box_filter_checker_pkg.sv -----
`timescale 1ns / 100ps

package box_filter_checker_pkg;
   import mbd_pkg::*;

   localparam int unsigned MAX_COLS     = 2048;
   localparam int unsigned LINE_ENTRIES = MAX_COLS / 2;

   // One expected output pixel with its flags
   typedef struct packed {
      pixel_type avg;
      logic      row_end;
      logic      image_end;
   } avg_block_type;

   // Tracks the 2x2 box filter and holds the output pixels still owed
   class box_filter_checker;
      pair_type      line_sums [LINE_ENTRIES];
      pair_type      lead_pair;
      int unsigned   col;
      int unsigned   row;
      int unsigned   width_reg;
      int unsigned   height_reg;
      avg_block_type blocks_due [$];
      int unsigned   errors;

      function new();
         foreach (line_sums[i]) line_sums[i] = '0;
         lead_pair  = '0;
         col        = 0;
         row        = 0;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
         if (idx == CSR_SOURCE_WIDTH) begin
            width_reg = value;
         end else begin
            height_reg = value;
         end
      endfunction

      function int unsigned clamp_size(int unsigned value, int unsigned hi);
         if (value < 2) return 2;
         if (value > hi) return hi;
         return value;
      endfunction

      // Truncated average of two pair sums
      function chan_type quarter(psum_type a, psum_type b);
         logic [BSUM_W-1:0] s;
         s = BSUM_W'(a) + BSUM_W'(b);
         return chan_type'(s >> 2);
      endfunction

      function bit at_image_start();
         return col == 0 && row == 0;
      endfunction

      function int unsigned pending();
         return blocks_due.size();
      endfunction

      // Advance the filter by one accepted source pixel
      function void note_pixel(pixel_type px);
         int unsigned   w;
         int unsigned   h;
         int unsigned   w_even;
         int unsigned   h_even;
         int unsigned   idx;
         pair_type      pair;
         avg_block_type blk;
         w      = clamp_size(width_reg, MAX_COLS);
         h      = clamp_size(height_reg, int'(ROW_LIMIT));
         w_even = w & ~32'd1;
         h_even = h & ~32'd1;

         if (col % 2 == 0) begin
            lead_pair.red   = PSUM_W'(px.red);
            lead_pair.green = PSUM_W'(px.green);
            lead_pair.blue  = PSUM_W'(px.blue);
            lead_pair.alpha = PSUM_W'(px.alpha);
         end else if (col < w_even && row < h_even) begin
            idx        = (col >> 1) % LINE_ENTRIES;
            pair.red   = lead_pair.red   + PSUM_W'(px.red);
            pair.green = lead_pair.green + PSUM_W'(px.green);
            pair.blue  = lead_pair.blue  + PSUM_W'(px.blue);
            pair.alpha = lead_pair.alpha + PSUM_W'(px.alpha);
            if (row % 2 == 0) begin
               line_sums[idx] = pair;
            end else begin
               blk.avg.red   = quarter(line_sums[idx].red,   pair.red);
               blk.avg.green = quarter(line_sums[idx].green, pair.green);
               blk.avg.blue  = quarter(line_sums[idx].blue,  pair.blue);
               blk.avg.alpha = quarter(line_sums[idx].alpha, pair.alpha);
               blk.row_end   = (col == w_even - 1);
               blk.image_end = (col == w_even - 1) && (row == h_even - 1);
               blocks_due.push_back(blk);
            end
         end

         // position of the next pixel
         if (col >= w - 1) begin
            col = 0;
            row = (row >= h - 1) ? 0 : row + 1;
         end else begin
            col = col + 1;
         end
      endfunction

      function void check_field(string name, int unsigned exp_v, int unsigned got_v);
         if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            errors++;
         end
      endfunction

      // Compare one output beat with the oldest owed pixel
      function void check_block(pixel_type got, logic row_end, logic image_end);
         avg_block_type want;
         if (blocks_due.size() == 0) begin
            $display("%0t: output beat with nothing expected, actual %h row_end %0d image_end %0d",
                     $time, got, row_end, image_end);
            errors++;
            return;
         end
         want = blocks_due.pop_front();
         check_field("red_out",   want.avg.red,   got.red);
         check_field("green_out", want.avg.green, got.green);
         check_field("blue_out",  want.avg.blue,  got.blue);
         check_field("alpha_out", want.avg.alpha, got.alpha);
         check_field("row_end",   want.row_end,   row_end);
         check_field("image_end", want.image_end, image_end);
      endfunction
   endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import mbd_pkg::*;
   import box_filter_checker_pkg::*;

   localparam int unsigned RANDOM_ITEMS  = 240;
   localparam int unsigned NO_IDLE_FROM  = 470;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned CYCLE_LIMIT   = 1500000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wdata;

   bit          no_idle;
   bit          hold_long;
   int unsigned random_sent;
   int unsigned total_sent;
   int unsigned cycles;

   box_filter_checker sb;

   mbd_req_if req ();
   mbd_rsp_if rsp ();

   mipmap_box_downsample_2x2_top #(
      .MAX_WIDTH (MAX_COLS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // output side: random stalls, one long hold-off on request
   initial begin
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // output monitor
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         sb.check_block({rsp.red_out, rsp.green_out, rsp.blue_out, rsp.alpha_out},
                        rsp.row_end, rsp.image_end);
      end
   end

   function automatic chan_type rand_chan();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return chan_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pixel_type rand_pixel();
      pixel_type px;
      px.red   = rand_chan();
      px.green = rand_chan();
      px.blue  = rand_chan();
      px.alpha = rand_chan();
      return px;
   endfunction

   // mostly in range, sometimes below range or larger than usual
   function automatic int unsigned pick_size(int unsigned normal_hi);
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 1);
         1:       return $urandom_range(13, 20);
         default: return $urandom_range(2, normal_hi);
      endcase
   endfunction

   // One source beat; valid stays high when the next beat follows at once
   task automatic send_pixel(pixel_type px);
      if (!no_idle && $urandom_range(0, 9) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.red_in   <= px.red;
      req.green_in <= px.green;
      req.blue_in  <= px.blue;
      req.alpha_in <= px.alpha;
      do @(posedge clock); while (!req.ready);
      sb.note_pixel(px);
      total_sent++;
      if (total_sent >= NO_IDLE_FROM) no_idle = 1'b1;
   endtask

   task automatic send_random(int unsigned count);
      repeat (count) begin
         send_pixel(rand_pixel());
         random_sent++;
      end
   endtask

   // Stop offering, let every owed pixel out, then let the pipe settle
   task automatic wait_drained();
      req.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_sizes(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
      csr_we    <= 1'b1;
      csr_index <= CSR_SOURCE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      sb.write_reg(CSR_SOURCE_WIDTH, w);
      csr_index <= CSR_SOURCE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      sb.write_reg(CSR_SOURCE_HEIGHT, h);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned img_px;
      int unsigned cut;
      int unsigned left;
      int unsigned burst;
      bit          first;

      sb = new();
      no_idle      = 1'b0;
      hold_long    = 1'b0;
      random_sent  = 0;
      total_sent   = 0;
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= CSR_SOURCE_WIDTH;
      csr_wdata    <= '0;
      req.valid    <= 1'b0;
      req.red_in   <= '0;
      req.green_in <= '0;
      req.blue_in  <= '0;
      req.alpha_in <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes: a full row and the head of the next, then a narrower
      // image so the column already past its end closes the image
      send_random(WIDTH_RESET + 4);
      wait_drained();
      write_sizes(12'd4, 12'd2);
      while (!sb.at_image_start()) send_random(1);

      // channel extremes and truncation on a 4x2 image
      wait_drained();
      write_sizes(12'd4, 12'd2);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_0000);
      send_pixel(32'h0100_FF03);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'hFFFF_FFFE);
      send_pixel(32'h0000_0000);
      send_pixel(32'h0201_FF00);

      // odd trailing column and row
      wait_drained();
      write_sizes(12'd5, 12'd3);
      for (int i = 0; i < 15; i++) begin
         send_pixel({8'(i * 17), 8'(~(i * 17)), 8'(i * 53), 8'(i * 3)});
      end

      // sizes below range run as 2x2
      wait_drained();
      write_sizes(12'd1, 12'd0);
      send_pixel(32'h8080_8080);
      send_pixel(32'h7F7F_7F7F);
      send_pixel(32'h01FE_01FE);
      send_pixel(32'hFE01_FE01);

      // sizes above range, each cut short by a smaller image
      wait_drained();
      write_sizes(12'd4095, 12'd2);
      send_random(6);
      wait_drained();
      write_sizes(12'd4, 12'd2);
      while (!sb.at_image_start()) send_random(1);
      wait_drained();
      write_sizes(12'd2, 12'd4095);
      send_random(8);
      wait_drained();
      write_sizes(12'd2, 12'd2);
      while (!sb.at_image_start()) send_random(1);

      // random images, some cut short by a resize part way through
      random_sent = 0;
      first = 1'b1;
      while (random_sent < RANDOM_ITEMS) begin
         if (first) begin
            w = 8;
            h = 8;
         end else begin
            w = pick_size(12);
            h = pick_size(10);
         end
         wait_drained();
         write_sizes(SIZE_W'(w), SIZE_W'(h));
         // first phase: output held off long enough to back up the input
         if (first) hold_long = 1'b1;
         first  = 1'b0;
         img_px = sb.clamp_size(w, MAX_COLS) * sb.clamp_size(h, int'(ROW_LIMIT));
         left   = RANDOM_ITEMS - random_sent;
         if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, img_px - 1);
            if (cut > left) cut = left;
            send_random(cut);
            wait_drained();
            write_sizes(SIZE_W'($urandom_range(0, 6)), SIZE_W'($urandom_range(0, 6)));
            while (!sb.at_image_start()) send_random(1);
         end else begin
            burst = $urandom_range(1, 3) * img_px;
            if (burst > left) burst = left;
            send_random(burst);
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
